FILE: sv/sp24_pkg.sv
// Shared types, widths and helpers for the 2:4 sparse dot product block.
`timescale 1ns / 1ps
`default_nettype none

package sp24_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int ACC_WIDTH   = 40;
  localparam int POS_WIDTH   = 2;
  localparam int PROD_WIDTH  = 2 * VALUE_WIDTH;
  localparam int BLK_WIDTH   = PROD_WIDTH + 1;
  localparam int SUM_WIDTH   = ((ACC_WIDTH > BLK_WIDTH) ? ACC_WIDTH : BLK_WIDTH) + 1;

  localparam logic [POS_WIDTH-1:0] POS_0 = POS_WIDTH'(0);
  localparam logic [POS_WIDTH-1:0] POS_1 = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] POS_2 = POS_WIDTH'(2);
  localparam logic [POS_WIDTH-1:0] POS_3 = POS_WIDTH'(3);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] weight_a;
    logic signed [VALUE_WIDTH-1:0] weight_b;
    logic [POS_WIDTH-1:0]          pos_a;
    logic [POS_WIDTH-1:0]          pos_b;
    logic signed [VALUE_WIDTH-1:0] vec_0;
    logic signed [VALUE_WIDTH-1:0] vec_1;
    logic signed [VALUE_WIDTH-1:0] vec_2;
    logic signed [VALUE_WIDTH-1:0] vec_3;
    logic                          last_block;
  } item_t;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] dot_product;
    logic                        saturated;
  } result_t;

  typedef struct packed {
    logic signed [BLK_WIDTH-1:0] block_sum;
    logic                        last_block;
  } blk_t;

  // Picks the vector element at a block position.
  function automatic logic signed [VALUE_WIDTH-1:0] sel_vec(input item_t it,
                                                           input logic [POS_WIDTH-1:0] pos);
    logic signed [VALUE_WIDTH-1:0] v;
    unique case (pos)
      POS_0:   v = it.vec_0;
      POS_1:   v = it.vec_1;
      POS_2:   v = it.vec_2;
      POS_3:   v = it.vec_3;
      default: v = it.vec_0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sp24_mac.sv
// Input register, position select and the two multipliers that form a block sum.
`timescale 1ns / 1ps
`default_nettype none

module sp24_mac (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire sp24_pkg::item_t item,
  output logic                blk_valid,
  input  wire logic           blk_ready,
  output sp24_pkg::blk_t      blk
);
  import sp24_pkg::*;

  item_t item_q;
  logic  s1_valid;
  logic  s2_take;

  logic signed [VALUE_WIDTH-1:0] vec_a;
  logic signed [VALUE_WIDTH-1:0] vec_b;
  logic signed [PROD_WIDTH-1:0]  prod_a;
  logic signed [PROD_WIDTH-1:0]  prod_b;
  blk_t                          blk_next;

  // Each stage moves when the one after it is empty or draining.
  assign s2_take    = !blk_valid || blk_ready;
  assign item_ready = !s1_valid || s2_take;

  always_comb begin
    vec_a  = sel_vec(item_q, item_q.pos_a);
    vec_b  = sel_vec(item_q, item_q.pos_b);
    prod_a = item_q.weight_a * vec_a;
    prod_b = item_q.weight_b * vec_b;
    blk_next.block_sum  = BLK_WIDTH'(prod_a) + BLK_WIDTH'(prod_b);
    blk_next.last_block = item_q.last_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      blk_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_take) begin
        blk_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
    if (s2_take && s1_valid) begin
      blk <= blk_next;
    end
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> s1_valid)
    else $error("accepted request did not reach the input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_take |=> s1_valid && $stable(item_q))
    else $error("input register changed while the block stage was stalled");

  a_blk_holds: assert property (@(posedge clk) disable iff (rst)
    blk_valid && !blk_ready |=> blk_valid && $stable(blk))
    else $error("block sum changed while the accumulator was stalled");

endmodule

`default_nettype wire

FILE: sv/sp24_acc.sv
// Saturating row accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none

module sp24_acc (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            blk_valid,
  output logic                 blk_ready,
  input  wire sp24_pkg::blk_t  blk,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output sp24_pkg::result_t    result
);
  import sp24_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0] row_sum;
  logic                        row_saturated;
  logic signed [ACC_WIDTH-1:0] row_sum_next;
  logic signed [SUM_WIDTH-1:0] sum_wide;
  logic                        over_hi;
  logic                        over_lo;
  logic                        sat;
  logic                        blk_fire;
  logic                        load;

  // A block that ends a row needs the result register free.
  assign blk_ready = !blk.last_block || !result_valid || result_ready;
  assign blk_fire  = blk_valid && blk_ready;
  assign load      = blk_fire && blk.last_block;

  always_comb begin
    sum_wide = SUM_WIDTH'(row_sum) + SUM_WIDTH'(blk.block_sum);
    over_hi  = !sum_wide[SUM_WIDTH-1] && (|sum_wide[SUM_WIDTH-2:ACC_WIDTH-1]);
    over_lo  = sum_wide[SUM_WIDTH-1] && !(&sum_wide[SUM_WIDTH-2:ACC_WIDTH-1]);
    sat      = over_hi || over_lo;
    if (over_hi) begin
      row_sum_next = ACC_MAX;
    end else if (over_lo) begin
      row_sum_next = ACC_MIN;
    end else begin
      row_sum_next = sum_wide[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum       <= '0;
      row_saturated <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (blk_fire) begin
        if (blk.last_block) begin
          row_sum       <= '0;
          row_saturated <= 1'b0;
        end else begin
          row_sum       <= row_sum_next;
          row_saturated <= row_saturated || sat;
        end
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.dot_product <= row_sum_next;
      result.saturated   <= row_saturated || sat;
    end
  end

  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    load |=> row_sum == '0 && !row_saturated)
    else $error("accumulator not cleared after the last block of a row");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    row_saturated && !load |=> row_saturated)
    else $error("saturation flag dropped inside a row");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> result_valid)
    else $error("row result not presented after the last block");

endmodule

`default_nettype wire

FILE: sv/sparse_2_4_dot_product.sv
// Top level of the 2:4 structured-sparse row dot product block.
`timescale 1ns / 1ps
`default_nettype none

// Each request on the item channel carries one block of a 2:4 sparse matrix row:
// two kept weights, their 2-bit positions, the four dense vector elements of the
// block and a last-block flag. Both products are formed exactly and added into a
// signed accumulator that saturates at its range and remembers that it did.
// A request with last_block set ends the row: one request leaves on the result
// channel with the saturated row sum and the saturation flag, and the
// accumulator and flag return to zero. Other blocks produce no result.
// The path is three registers deep: input register, block-sum register (set by
// the two multipliers), then the accumulator and result register. A row result
// is valid after its last block passes the input and block-sum registers. One
// block is taken every cycle unless stalled; the accumulate loop sets the rate.
// When the receiver stalls, the result register holds and a following last
// block waits in the block-sum stage; blocks that do not end a row keep
// accumulating, and backpressure reaches item_ready only when stages fill.
// Synchronous reset empties all stages and clears the accumulator and flag.

module sparse_2_4_dot_product (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire sp24_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output sp24_pkg::result_t     result
);
  import sp24_pkg::*;

  logic blk_valid;
  logic blk_ready;
  blk_t blk;

  sp24_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .blk_valid  (blk_valid),
    .blk_ready  (blk_ready),
    .blk        (blk)
  );

  sp24_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .blk_valid    (blk_valid),
    .blk_ready    (blk_ready),
    .blk          (blk),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
